FILE: hdl/agif_pkg.sv
// Shared types and constants for the allocation group inefficiency flags block.
`default_nettype none

package agif_pkg;

  localparam int unsigned TimeBits    = 48;
  localparam int unsigned RunBits     = 16;
  localparam int unsigned CountBits   = 32;
  localparam int unsigned SizeBits    = 32;
  localparam int unsigned LimitBits   = 48;
  localparam int unsigned GrowthBits  = 16;
  localparam int unsigned CovBits     = 17;
  localparam int unsigned CovFracBits = 16;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 48;

  // Comparison widths that cover both operands.
  localparam int unsigned LifeCmpBits = (TimeBits > LimitBits) ? TimeBits : LimitBits;
  localparam int unsigned RunCmpBits  = (RunBits > GrowthBits) ? RunBits : GrowthBits;
  localparam int unsigned ProdBits    = CovBits + SizeBits;

  localparam logic [RunBits-1:0] RunMax = '1;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_SHORT_LIFE = 2'd0,
    CFG_GROWTH_RUN = 2'd1,
    CFG_COVERAGE   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [LimitBits-1:0]  short_life_limit;
    logic [GrowthBits-1:0] min_growth_run;
    logic [CovBits-1:0]    coverage_limit;
  } cfg_t;

  typedef struct packed {
    logic [TimeBits-1:0]  alloc_time;
    logic [TimeBits-1:0]  free_time;
    logic [TimeBits-1:0]  first_touch_time;
    logic [TimeBits-1:0]  last_touch_time;
    logic [CountBits-1:0] read_count;
    logic [CountBits-1:0] write_count;
    logic [SizeBits-1:0]  chunk_bytes;
    logic [SizeBits-1:0]  touched_low;
    logic [SizeBits-1:0]  touched_high;
    logic                 shared_by_threads;
    logic                 group_end;
  } rec_t;

  typedef struct packed {
    logic short_lived;
    logic write_only;
    logic read_only;
    logic never_used;
    logic early_alloc;
    logic late_free;
    logic growing_reallocs;
    logic multi_threaded;
    logic low_coverage;
  } flags_t;

endpackage

`default_nettype wire

FILE: hdl/allocation_group_inefficiency_flags.sv
// Top level of the allocation group inefficiency flags block.
//
// Records of one call site's allocation group arrive on the input channel
// (in_valid_i / in_stall_o), one transfer per record. The record with
// group_end set closes the group: it yields one transfer of nine flags on
// the output channel (out_valid_o / out_stall_i), and the group state is
// cleared. Other records yield nothing.
// A record is registered at its transfer and folded into the group state
// from the input register, a closing record only once the result register
// can take its flags; those flags are then held there behind out_valid_o.
// One record is taken per cycle while in_stall_o is low; the fold stage with its 17 x 32 coverage
// multiply sits between the input and result registers.
// When the receiver stalls, the held result stays put and further records
// that do not close a group are still folded in; a second closing record
// waits in the input register and in_stall_o rises until the result moves.
// Reset clears the group state and the three configuration registers.
// Configuration writes (cfg_valid_i / cfg_ready_o) are always taken and
// should be made while no record is in flight.
`default_nettype none

module allocation_group_inefficiency_flags (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [agif_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [agif_pkg::CfgDataBits-1:0] cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [agif_pkg::TimeBits-1:0]    alloc_time_i,
  input  wire logic [agif_pkg::TimeBits-1:0]    free_time_i,
  input  wire logic [agif_pkg::TimeBits-1:0]    first_touch_time_i,
  input  wire logic [agif_pkg::TimeBits-1:0]    last_touch_time_i,
  input  wire logic [agif_pkg::CountBits-1:0]   read_count_i,
  input  wire logic [agif_pkg::CountBits-1:0]   write_count_i,
  input  wire logic [agif_pkg::SizeBits-1:0]    chunk_bytes_i,
  input  wire logic [agif_pkg::SizeBits-1:0]    touched_low_i,
  input  wire logic [agif_pkg::SizeBits-1:0]    touched_high_i,
  input  wire logic                             shared_by_threads_i,
  input  wire logic                             group_end_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  short_lived_o,
  output logic                                  write_only_o,
  output logic                                  read_only_o,
  output logic                                  never_used_o,
  output logic                                  early_alloc_o,
  output logic                                  late_free_o,
  output logic                                  growing_reallocs_o,
  output logic                                  multi_threaded_o,
  output logic                                  low_coverage_o
);
  import agif_pkg::*;

  cfg_t   cfg;
  rec_t   rec_in;
  rec_t   rec;
  logic   rec_valid;
  flags_t flags;
  flags_t flags_q;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   fold_ok;
  logic   fold;
  logic   load_result;

  assign rec_in.alloc_time        = alloc_time_i;
  assign rec_in.free_time         = free_time_i;
  assign rec_in.first_touch_time  = first_touch_time_i;
  assign rec_in.last_touch_time   = last_touch_time_i;
  assign rec_in.read_count        = read_count_i;
  assign rec_in.write_count       = write_count_i;
  assign rec_in.chunk_bytes       = chunk_bytes_i;
  assign rec_in.touched_low       = touched_low_i;
  assign rec_in.touched_high      = touched_high_i;
  assign rec_in.shared_by_threads = shared_by_threads_i;
  assign rec_in.group_end         = group_end_i;

  agif_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // A closing record may fold only when the result register can take its flags.
  assign out_free    = !out_valid_q || !out_stall_i;
  assign fold_ok     = !rec.group_end || out_free;
  assign fold        = rec_valid && fold_ok;
  assign load_result = fold && rec.group_end;

  agif_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rec_i       (rec_in),
    .fold_ok_i   (fold_ok),
    .rec_valid_o (rec_valid),
    .rec_o       (rec)
  );

  agif_fold u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fold_i  (fold),
    .rec_i   (rec),
    .cfg_i   (cfg),
    .flags_o (flags)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_result) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_result) begin
      flags_q <= flags;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign short_lived_o      = flags_q.short_lived;
  assign write_only_o       = flags_q.write_only;
  assign read_only_o        = flags_q.read_only;
  assign never_used_o       = flags_q.never_used;
  assign early_alloc_o      = flags_q.early_alloc;
  assign late_free_o        = flags_q.late_free;
  assign growing_reallocs_o = flags_q.growing_reallocs;
  assign multi_threaded_o   = flags_q.multi_threaded;
  assign low_coverage_o     = flags_q.low_coverage;

endmodule

`default_nettype wire

FILE: hdl/agif_cfg_regs.sv
// Configuration registers of the allocation group inefficiency flags block.
`default_nettype none

module agif_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [agif_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [agif_pkg::CfgDataBits-1:0] cfg_data_i,
  output agif_pkg::cfg_t                        cfg_o
);
  import agif_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SHORT_LIFE: cfg_d.short_life_limit = cfg_data_i[LimitBits-1:0];
        CFG_GROWTH_RUN: cfg_d.min_growth_run   = cfg_data_i[GrowthBits-1:0];
        CFG_COVERAGE:   cfg_d.coverage_limit   = cfg_data_i[CovBits-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hdl/agif_in_stage.sv
// Input register that holds one record until it is folded into the group state.
`default_nettype none

module agif_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire agif_pkg::rec_t rec_i,
  input  wire logic           fold_ok_i,
  output logic                rec_valid_o,
  output agif_pkg::rec_t      rec_o
);
  import agif_pkg::*;

  logic rec_valid_q, rec_valid_d;
  rec_t rec_q;
  logic advance;
  logic take;

  // The held record leaves when it is folded this cycle.
  assign advance    = rec_valid_q && fold_ok_i;
  assign in_stall_o = rec_valid_q && !fold_ok_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    rec_valid_d = rec_valid_q;
    if (take) begin
      rec_valid_d = 1'b1;
    end else if (advance) begin
      rec_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_valid_q <= 1'b0;
    end else begin
      rec_valid_q <= rec_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rec_q <= rec_i;
    end
  end

  assign rec_valid_o = rec_valid_q;
  assign rec_o       = rec_q;

endmodule

`default_nettype wire

FILE: hdl/agif_fold.sv
// Per-record terms and the sticky group state, with the flags of a closing group.
`default_nettype none

module agif_fold (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           fold_i,
  input  wire agif_pkg::rec_t rec_i,
  input  wire agif_pkg::cfg_t cfg_i,
  output agif_pkg::flags_t    flags_o
);
  import agif_pkg::*;

  logic [TimeBits-1:0] shortest_q, shortest_d;
  logic                reads_q, reads_d;
  logic                writes_q, writes_d;
  logic                early_q, early_d;
  logic                late_q, late_d;
  logic                threads_q, threads_d;
  logic                sparse_q, sparse_d;
  logic [SizeBits-1:0] prev_size_q, prev_size_d;
  logic [RunBits-1:0]  run_q, run_d;
  logic [RunBits-1:0]  best_q, best_d;

  logic [TimeBits-1:0] life;
  logic [TimeBits-1:0] half_life;
  logic [TimeBits-1:0] idle_before;
  logic [TimeBits-1:0] idle_after;
  logic [SizeBits-1:0] span;
  logic [ProdBits-1:0] span_scaled;
  logic [ProdBits-1:0] cov_prod;
  logic [RunBits-1:0]  run_n, best_n, longest;
  logic [TimeBits-1:0] min_life;
  logic                reads_n, writes_n;

  assign life        = rec_i.free_time - rec_i.alloc_time;
  assign half_life   = life >> 1;
  assign idle_before = rec_i.first_touch_time - rec_i.alloc_time;
  assign idle_after  = rec_i.free_time - rec_i.last_touch_time;
  assign span        = rec_i.touched_high - rec_i.touched_low;
  assign span_scaled = ProdBits'({span, {CovFracBits{1'b0}}});
  assign cov_prod    = ProdBits'(cfg_i.coverage_limit) * ProdBits'(rec_i.chunk_bytes);

  always_comb begin
    min_life = (life < shortest_q) ? life : shortest_q;
    reads_n  = reads_q || (rec_i.read_count != '0);
    writes_n = writes_q || (rec_i.write_count != '0);

    // A size below the previous one closes the current run.
    if (rec_i.chunk_bytes >= prev_size_q) begin
      run_n  = (run_q == RunMax) ? run_q : run_q + 1'b1;
      best_n = best_q;
    end else begin
      run_n  = RunBits'(1);
      best_n = (run_q > best_q) ? run_q : best_q;
    end
    longest = (run_n > best_n) ? run_n : best_n;
  end

  always_comb begin
    shortest_d  = shortest_q;
    reads_d     = reads_q;
    writes_d    = writes_q;
    early_d     = early_q;
    late_d      = late_q;
    threads_d   = threads_q;
    sparse_d    = sparse_q;
    prev_size_d = prev_size_q;
    run_d       = run_q;
    best_d      = best_q;
    if (fold_i) begin
      if (rec_i.group_end) begin
        shortest_d  = '1;
        reads_d     = 1'b0;
        writes_d    = 1'b0;
        early_d     = 1'b0;
        late_d      = 1'b0;
        threads_d   = 1'b0;
        sparse_d    = 1'b0;
        prev_size_d = '0;
        run_d       = '0;
        best_d      = '0;
      end else begin
        shortest_d  = min_life;
        reads_d     = reads_n;
        writes_d    = writes_n;
        early_d     = early_q || (idle_before > half_life);
        late_d      = late_q || (idle_after > half_life);
        threads_d   = threads_q || rec_i.shared_by_threads;
        sparse_d    = sparse_q || (span_scaled < cov_prod);
        prev_size_d = rec_i.chunk_bytes;
        run_d       = run_n;
        best_d      = best_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shortest_q  <= '1;
      reads_q     <= 1'b0;
      writes_q    <= 1'b0;
      early_q     <= 1'b0;
      late_q      <= 1'b0;
      threads_q   <= 1'b0;
      sparse_q    <= 1'b0;
      prev_size_q <= '0;
      run_q       <= '0;
      best_q      <= '0;
    end else begin
      shortest_q  <= shortest_d;
      reads_q     <= reads_d;
      writes_q    <= writes_d;
      early_q     <= early_d;
      late_q      <= late_d;
      threads_q   <= threads_d;
      sparse_q    <= sparse_d;
      prev_size_q <= prev_size_d;
      run_q       <= run_d;
      best_q      <= best_d;
    end
  end

  // Flags as they stand with the current record folded in.
  always_comb begin
    flags_o.short_lived      = LifeCmpBits'(min_life) <= LifeCmpBits'(cfg_i.short_life_limit);
    flags_o.write_only       = writes_n && !reads_n;
    flags_o.read_only        = reads_n && !writes_n;
    flags_o.never_used       = !reads_n && !writes_n;
    flags_o.early_alloc      = early_q || (idle_before > half_life);
    flags_o.late_free        = late_q || (idle_after > half_life);
    flags_o.growing_reallocs = RunCmpBits'(longest) >= RunCmpBits'(cfg_i.min_growth_run);
    flags_o.multi_threaded   = threads_q || rec_i.shared_by_threads;
    flags_o.low_coverage     = sparse_q || (span_scaled < cov_prod);
  end

endmodule

`default_nettype wire

FILE: hdl/agif_checker.sv
// Port-level checks for the allocation group inefficiency flags block, bound to its top level.
`default_nettype none

module agif_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic short_lived_o,
  input wire logic write_only_o,
  input wire logic read_only_o,
  input wire logic never_used_o,
  input wire logic early_alloc_o,
  input wire logic late_free_o,
  input wire logic growing_reallocs_o,
  input wire logic multi_threaded_o,
  input wire logic low_coverage_o
);

  // A result held by the receiver keeps its valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A result held by the receiver keeps its flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable({short_lived_o, write_only_o, read_only_o, never_used_o, early_alloc_o,
               late_free_o, growing_reallocs_o, multi_threaded_o, low_coverage_o}))
    else $error("result flags changed while stalled");

  // The input side only backs up behind a blocked result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // The access class flags are mutually exclusive.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({write_only_o, read_only_o, never_used_o}) <= 1)
    else $error("conflicting access class flags");

endmodule

bind allocation_group_inefficiency_flags agif_checker u_agif_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .short_lived_o      (short_lived_o),
  .write_only_o       (write_only_o),
  .read_only_o        (read_only_o),
  .never_used_o       (never_used_o),
  .early_alloc_o      (early_alloc_o),
  .late_free_o        (late_free_o),
  .growing_reallocs_o (growing_reallocs_o),
  .multi_threaded_o   (multi_threaded_o),
  .low_coverage_o     (low_coverage_o)
);

`default_nettype wire
